[hdl/polyec_pkg.sv]
// shared types and constants for the polygon ear clipping unit
// used by polygon_convex_split_ear_clip_unit; no dependencies
package polyec_pkg;

  localparam int FIELD_W = 16;
  localparam int PIECE_W = 4;
  localparam int DATA_W  = 32;
  localparam int USER_W  = 8;

  // one result word before packing onto the stream
  typedef struct packed {
    logic                 drop;
    logic                 cvx;
    logic                 rend;
    logic                 pend;
    logic                 cv;
    logic [PIECE_W-1:0]   piece;
    logic [FIELD_W-1:0]   y;
    logic [FIELD_W-1:0]   x;
  } out_t;

endpackage

[hdl/polygon_convex_split_ear_clip_unit.sv]
// polygon ear clipping unit: loads vertices, emits convex polygon or ear triangles
// loading: vertices are accepted while idle; compute runs a convex test per corner, a shoelace
// sum per edge if the polygon is not convex, then ear passes over the remaining corners,
// all on one shared signed multiplier used twice per cross product
// throughput: one polygon at a time; input not ready while computing
// reset: async active-low clears control, vertex and order stores are not cleared
module polygon_convex_split_ear_clip_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [polyec_pkg::DATA_W-1:0] s_axis_tdata_i,   // point_x[15:0], point_y[31:16]
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [polyec_pkg::DATA_W-1:0] m_axis_tdata_o,   // out_x[15:0], out_y[31:16]
  // piece_number[3:0], corner_valid[4], piece_end[5], was_convex[6], dropped_vertices[7]
  output logic [polyec_pkg::USER_W-1:0] m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import polyec_pkg::*;

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int CNW = $clog2(MAX_VERTICES + 1);
  localparam int CW  = COORD_WIDTH;
  localparam int OW  = CW + 1;
  localparam int PW  = 2 * OW;
  localparam int XW  = PW + 1;
  localparam int AW  = XW + 5;
  localparam int EW  = (CW > FIELD_W) ? CW : FIELD_W;
  localparam logic [CNW-1:0] ONE   = CNW'(1);
  localparam logic [CNW-1:0] THREE = CNW'(3);
  localparam logic [CNW-1:0] MAXV  = CNW'(MAX_VERTICES);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } pt_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_FETCH, ST_OPS, ST_MUL1, ST_MUL2, ST_CV_EVAL, ST_CV_EMIT,
    ST_AREA_ACC, ST_PASS, ST_EAR_TURN, ST_NEXT, ST_IN_FETCH, ST_IN_EVAL, ST_TRI,
    ST_SHIFT, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {M_CONV, M_AREA, M_EAR, M_LAST} mode_e;
  typedef enum logic [2:0] {OP_TURN, OP_RAW, OP_S0, OP_S1, OP_S2} opsel_e;

  function automatic logic [CW-1:0] from16(logic [FIELD_W-1:0] v);
    logic [EW-1:0] e;
    e = '0;
    e[FIELD_W-1:0] = v;
    return e[CW-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to16(logic [CW-1:0] v);
    logic [EW-1:0] e;
    e = '0;
    e[CW-1:0] = v;
    return e[FIELD_W-1:0];
  endfunction

  function automatic logic signed [OW-1:0] sx(logic [CW-1:0] v);
    return $signed({v[CW-1], v});
  endfunction

  state_e state_q;
  mode_e  mode_q;
  opsel_e opsel_q;
  pt_t    vs_q [MAX_VERTICES];
  logic [IW-1:0] ord_q [MAX_VERTICES];
  logic [CNW-1:0] cnt_q, rc_q, i_q, j_q;
  logic ovf_q, rev_q, pos_q, neg_q;
  logic [1:0] f_q, s_q, t_q;
  pt_t a_q, b_q, c_q, p_q;
  logic signed [OW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [XW-1:0] cr_q;
  logic signed [AW-1:0] acc_q;
  logic [PIECE_W-1:0] piece_q;
  out_t hold_q, out_q;
  logic hold_v_q, out_v_q;

  logic s_acc, out_free, can_push, push_fire, fin_fire, out_v_d;
  logic [CNW-1:0] prev_i, next_i, rpos, o_ext, phys;
  logic [IW-1:0] ord_rd;
  pt_t rd_pt, push_pt;
  logic signed [OW-1:0] mul_a, mul_b, ux_d, uy_d, vx_d, vy_d;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] prod_x;
  logic signed [AW-1:0] acc_d;
  logic cr_pos, cr_neg, same_abc, pos_d, neg_d;
  out_t push_item, fin_item;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign can_push = !hold_v_q || out_free;
  assign push_fire = (state_q == ST_CV_EMIT || state_q == ST_TRI) && can_push;
  assign fin_fire  = (state_q == ST_FINISH) && out_free;

  always_comb begin
    if ((push_fire && hold_v_q) || fin_fire) begin
      out_v_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end else begin
      out_v_d = out_v_q;
    end
  end

  // last word of a run: the held word, or an empty terminal word
  always_comb begin
    if (hold_v_q) begin
      fin_item = hold_q;
    end else begin
      fin_item = '0;
      fin_item.drop = ovf_q;
    end
    fin_item.rend = 1'b1;
  end

  assign prev_i = (i_q == '0) ? rc_q - ONE : i_q - ONE;
  assign next_i = (i_q == rc_q - ONE) ? '0 : i_q + ONE;

  always_comb begin
    unique case (state_q)
      ST_FETCH: begin
        unique case (f_q)
          2'd0:    rpos = prev_i;
          2'd1:    rpos = i_q;
          default: rpos = next_i;
        endcase
      end
      ST_IN_FETCH: rpos = j_q;
      ST_SHIFT:    rpos = j_q + ONE;
      default:     rpos = i_q;
    endcase
  end

  // order lookup, then winding reversal by index mapping
  assign ord_rd = ord_q[rpos[IW-1:0]];
  assign o_ext  = CNW'(ord_rd);
  assign phys   = rev_q ? cnt_q - ONE - o_ext : o_ext;
  assign rd_pt  = vs_q[phys[IW-1:0]];

  assign same_abc = (rd_pt == a_q) || (rd_pt == b_q) || (rd_pt == c_q);

  // shared multiplier: first product in mul1, subtracted product in mul2
  assign mul_a  = (state_q == ST_MUL2) ? uy_q : ux_q;
  assign mul_b  = (state_q == ST_MUL2) ? vx_q : vy_q;
  assign prod   = mul_a * mul_b;
  assign prod_x = XW'(prod);
  assign acc_d  = acc_q + AW'(cr_q);
  assign cr_pos = !cr_q[XW-1] && (cr_q != '0);
  assign cr_neg = cr_q[XW-1];
  assign pos_d  = pos_q || cr_pos;
  assign neg_d  = neg_q || cr_neg;

  always_comb begin
    unique case (opsel_q)
      OP_TURN: begin
        ux_d = sx(b_q.x) - sx(a_q.x); uy_d = sx(b_q.y) - sx(a_q.y);
        vx_d = sx(c_q.x) - sx(b_q.x); vy_d = sx(c_q.y) - sx(b_q.y);
      end
      OP_RAW: begin
        ux_d = sx(b_q.x); uy_d = sx(b_q.y);
        vx_d = sx(c_q.x); vy_d = sx(c_q.y);
      end
      OP_S0: begin
        ux_d = sx(b_q.x) - sx(a_q.x); uy_d = sx(b_q.y) - sx(a_q.y);
        vx_d = sx(p_q.x) - sx(a_q.x); vy_d = sx(p_q.y) - sx(a_q.y);
      end
      OP_S1: begin
        ux_d = sx(c_q.x) - sx(b_q.x); uy_d = sx(c_q.y) - sx(b_q.y);
        vx_d = sx(p_q.x) - sx(b_q.x); vy_d = sx(p_q.y) - sx(b_q.y);
      end
      default: begin
        ux_d = sx(a_q.x) - sx(c_q.x); uy_d = sx(a_q.y) - sx(c_q.y);
        vx_d = sx(p_q.x) - sx(c_q.x); vy_d = sx(p_q.y) - sx(c_q.y);
      end
    endcase
  end

  always_comb begin
    if (state_q == ST_CV_EMIT) begin
      push_pt = rd_pt;
    end else begin
      unique case (t_q)
        2'd0:    push_pt = a_q;
        2'd1:    push_pt = b_q;
        default: push_pt = c_q;
      endcase
    end
    push_item.x     = to16(push_pt.x);
    push_item.y     = to16(push_pt.y);
    push_item.piece = (state_q == ST_CV_EMIT) ? '0 : piece_q;
    push_item.cv    = 1'b1;
    push_item.pend  = (state_q == ST_CV_EMIT) ? (i_q == cnt_q - ONE) : (t_q == 2'd2);
    push_item.rend  = 1'b0;
    push_item.cvx   = (state_q == ST_CV_EMIT);
    push_item.drop  = ovf_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && (cnt_q < MAXV)) begin
      vs_q[cnt_q[IW-1:0]].x <= from16(s_axis_tdata_i[FIELD_W-1:0]);
      vs_q[cnt_q[IW-1:0]].y <= from16(s_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_START) begin
      for (int k = 0; k < MAX_VERTICES; k++) ord_q[k] <= IW'(k);
    end else if (state_q == ST_SHIFT && (j_q + ONE < rc_q)) begin
      ord_q[j_q[IW-1:0]] <= ord_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= M_CONV;
      opsel_q  <= OP_TURN;
      cnt_q    <= '0;
      rc_q     <= '0;
      i_q      <= '0;
      j_q      <= '0;
      f_q      <= '0;
      s_q      <= '0;
      t_q      <= '0;
      ovf_q    <= 1'b0;
      rev_q    <= 1'b0;
      pos_q    <= 1'b0;
      neg_q    <= 1'b0;
      piece_q  <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            if (cnt_q < MAXV) cnt_q <= cnt_q + ONE;
            else ovf_q <= 1'b1;
            if (s_axis_tlast_i) state_q <= ST_START;
          end
        end
        ST_START: begin
          i_q     <= '0;
          f_q     <= '0;
          mode_q  <= M_CONV;
          rc_q    <= cnt_q;
          rev_q   <= 1'b0;
          pos_q   <= 1'b0;
          neg_q   <= 1'b0;
          piece_q <= '0;
          state_q <= (cnt_q < THREE) ? ST_FINISH : ST_FETCH;
        end
        ST_FETCH: begin
          unique case (f_q)
            2'd0:    a_q <= rd_pt;
            2'd1:    b_q <= rd_pt;
            default: c_q <= rd_pt;
          endcase
          if (f_q == 2'd2) begin
            if (mode_q == M_LAST) begin
              t_q     <= '0;
              state_q <= ST_TRI;
            end else begin
              opsel_q <= (mode_q == M_AREA) ? OP_RAW : OP_TURN;
              state_q <= ST_OPS;
            end
          end else begin
            f_q <= f_q + 2'd1;
          end
        end
        ST_OPS: begin
          ux_q <= ux_d; uy_q <= uy_d; vx_q <= vx_d; vy_q <= vy_d;
          state_q <= ST_MUL1;
        end
        ST_MUL1: begin
          cr_q    <= prod_x;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          cr_q <= cr_q - prod_x;
          if (opsel_q == OP_S0 || opsel_q == OP_S1 || opsel_q == OP_S2) begin
            state_q <= ST_IN_EVAL;
          end else begin
            unique case (mode_q)
              M_CONV:  state_q <= ST_CV_EVAL;
              M_AREA:  state_q <= ST_AREA_ACC;
              default: state_q <= ST_EAR_TURN;
            endcase
          end
        end
        ST_CV_EVAL: begin
          pos_q <= pos_d;
          neg_q <= neg_d;
          if (pos_d && neg_d) begin
            acc_q   <= '0;
            i_q     <= '0;
            f_q     <= 2'd1;
            mode_q  <= M_AREA;
            state_q <= ST_FETCH;
          end else if (i_q == cnt_q - ONE) begin
            i_q     <= '0;
            state_q <= ST_CV_EMIT;
          end else begin
            i_q     <= i_q + ONE;
            f_q     <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_CV_EMIT: begin
          if (can_push) begin
            if (i_q == cnt_q - ONE) state_q <= ST_FINISH;
            else i_q <= i_q + ONE;
          end
        end
        ST_AREA_ACC: begin
          acc_q <= acc_d;
          if (i_q == cnt_q - ONE) begin
            rev_q   <= acc_d[AW-1];
            state_q <= ST_PASS;
          end else begin
            i_q     <= i_q + ONE;
            f_q     <= 2'd1;
            state_q <= ST_FETCH;
          end
        end
        ST_PASS: begin
          f_q <= '0;
          if (rc_q > THREE) begin
            i_q     <= '0;
            mode_q  <= M_EAR;
            state_q <= ST_FETCH;
          end else if (rc_q == THREE) begin
            i_q     <= ONE;
            mode_q  <= M_LAST;
            state_q <= ST_FETCH;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_EAR_TURN: begin
          if (cr_pos) begin
            j_q     <= '0;
            state_q <= ST_IN_FETCH;
          end else begin
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (i_q == rc_q - ONE) begin
            state_q <= ST_FINISH;
          end else begin
            i_q     <= i_q + ONE;
            f_q     <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_IN_FETCH: begin
          if (j_q == rc_q) begin
            t_q     <= '0;
            state_q <= ST_TRI;
          end else if (same_abc) begin
            j_q <= j_q + ONE;
          end else begin
            p_q     <= rd_pt;
            s_q     <= '0;
            pos_q   <= 1'b0;
            neg_q   <= 1'b0;
            opsel_q <= OP_S0;
            state_q <= ST_OPS;
          end
        end
        ST_IN_EVAL: begin
          pos_q <= pos_d;
          neg_q <= neg_d;
          if (s_q == 2'd2) begin
            // boundary counts as inside
            if (!(pos_d && neg_d)) begin
              state_q <= ST_NEXT;
            end else begin
              j_q     <= j_q + ONE;
              state_q <= ST_IN_FETCH;
            end
          end else begin
            s_q     <= s_q + 2'd1;
            opsel_q <= (s_q == 2'd0) ? OP_S1 : OP_S2;
            state_q <= ST_OPS;
          end
        end
        ST_TRI: begin
          if (can_push) begin
            if (t_q == 2'd2) begin
              piece_q <= piece_q + PIECE_W'(1);
              if (mode_q == M_LAST) begin
                state_q <= ST_FINISH;
              end else begin
                j_q     <= i_q;
                state_q <= ST_SHIFT;
              end
            end else begin
              t_q <= t_q + 2'd1;
            end
          end
        end
        ST_SHIFT: begin
          if (j_q + ONE < rc_q) begin
            j_q <= j_q + ONE;
          end else begin
            rc_q    <= rc_q - ONE;
            state_q <= ST_PASS;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_q    <= fin_item;
            hold_v_q <= 1'b0;
            cnt_q    <= '0;
            ovf_q    <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // one word of lookahead so the last word can carry the run end mark
      if (push_fire) begin
        if (hold_v_q) begin
          out_q <= hold_q;
        end
        hold_q   <= push_item;
        hold_v_q <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_q.y, out_q.x};
  assign m_axis_tuser_o  = {out_q.drop, out_q.cvx, out_q.pend, out_q.cv, out_q.piece};
  assign m_axis_tlast_o  = out_q.rend;

`ifndef ASSERT_OFF
  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !hold_v_q) else $error("lookahead word left over in idle");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAXV) else $error("vertex count beyond capacity");
  a_terminal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_q.cv) |-> out_q.rend) else $error("empty word not last");
  a_rc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (rc_q > THREE && rc_q <= cnt_q)) else $error("bad clip count");
`endif

endmodule
